// File: hdl/adpcm_pkg.sv
// Shared constants and types for the DSP ADPCM decoder.
`default_nettype none
package adpcm_pkg;

   localparam int COEF_PAIRS  = 8;
   localparam int SEL_W       = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int COEF_W      = 16;
   localparam int SAMPLE_W    = 16;
   localparam int BYTE_W      = 8;
   localparam int NIB_W       = 4;
   localparam int SHIFT_W     = 4;
   localparam int POS_W       = 3;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int ACC_W       = PROD_W + 1;
   localparam int SCALE_W     = 20;
   localparam int SUM_W       = 24;
   localparam int PRED_SHIFT  = 11;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(33'sh400);
   localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(24'sh007FFF);
   localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(24'sh007FFF);

   localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);

   typedef struct packed {
      logic en;
      logic load;
   } mac_ctl_type;

endpackage
`default_nettype wire

// File: hdl/adpcm_if.sv
// Channel interfaces: compressed byte input, sample pair output, register write port.
`default_nettype none
interface adpcm_req_if;
   logic                            valid;
   logic                            ready;
   logic [adpcm_pkg::BYTE_W-1:0]    data_byte;
   logic                            channel_start;

   modport source (output valid, output data_byte, output channel_start, input ready);
   modport sink (input valid, input data_byte, input channel_start, output ready);
endinterface

interface adpcm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] first_sample;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] second_sample;

   modport source (output valid, output first_sample, output second_sample, input ready);
   modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

interface adpcm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [adpcm_pkg::CSR_INDEX_W-1:0]    index;
   logic [adpcm_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/dsp_adpcm_decoder.sv
// Top level of the DSP ADPCM decoder: byte sequencer, history and output register.
//
// Decodes one channel of 4-bit DSP ADPCM, one byte per input word. A header byte
// (first of each 8-byte frame, or any byte with channel_start set) is stored as the
// frame header and gives no output. For a data byte, each of its two nibbles uses
// the shared 16x16 multiply-accumulate unit in two steps (c1*h1, then c2*h2) and
// then a step to scale, clamp and update the history; last, the sample pair moves
// into the output register. That last step waits while the output register still
// holds an untaken word. Coefficient writes are taken every cycle.
`default_nettype none
module dsp_adpcm_decoder (
   input  wire logic   clock,
   input  wire logic   reset,
   adpcm_req_if.sink   req_port,
   adpcm_rsp_if.source rsp_port,
   adpcm_csr_if.sink   csr_port
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD1,
      ST_PROD2,
      ST_SAMPLE,
      ST_PUSH
   } state_type;

   state_type                                state_ff, state_in;
   logic [adpcm_pkg::POS_W-1:0]              pos_ff, pos_in;
   logic [adpcm_pkg::BYTE_W-1:0]             header_ff, header_in;
   logic [adpcm_pkg::BYTE_W-1:0]             byte_ff, byte_in;
   logic                                     nib_sel_ff, nib_sel_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    hist1_ff, hist1_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    hist2_ff, hist2_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    first_ff, first_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    second_ff, second_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    rsp_first_ff, rsp_first_in;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    rsp_second_ff, rsp_second_in;

   logic                                     req_take;
   logic [adpcm_pkg::POS_W-1:0]              pos_eff;
   logic signed [adpcm_pkg::COEF_W-1:0]      coef1;
   logic signed [adpcm_pkg::COEF_W-1:0]      coef2;
   adpcm_pkg::mac_ctl_type                   mac_ctl;
   logic signed [adpcm_pkg::COEF_W-1:0]      mac_a;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    mac_b;
   logic signed [adpcm_pkg::ACC_W-1:0]       acc;
   logic signed [adpcm_pkg::NIB_W-1:0]       nib;
   logic signed [adpcm_pkg::SCALE_W-1:0]     scaled;
   logic signed [adpcm_pkg::SUM_W-1:0]       pred;
   logic signed [adpcm_pkg::SUM_W-1:0]       sum;
   logic signed [adpcm_pkg::SAMPLE_W-1:0]    sample;
   logic                                     out_free;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   adpcm_coef u_coef (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_port.valid && csr_port.ready),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .rd_sel   (header_ff[6:4]),
      .coef1    (coef1),
      .coef2    (coef2)
   );

   always_comb begin
      mac_ctl.en   = (state_ff == ST_PROD1) || (state_ff == ST_PROD2);
      mac_ctl.load = (state_ff == ST_PROD1);
      mac_a        = (state_ff == ST_PROD1) ? coef1 : coef2;
      mac_b        = (state_ff == ST_PROD1) ? hist1_ff : hist2_ff;
   end

   adpcm_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   always_comb begin
      nib    = nib_sel_ff ? byte_ff[3:0] : byte_ff[7:4];
      scaled = adpcm_pkg::SCALE_W'(nib) <<< header_ff[adpcm_pkg::SHIFT_W-1:0];
      pred   = adpcm_pkg::SUM_W'(acc >>> adpcm_pkg::PRED_SHIFT);
      sum    = adpcm_pkg::SUM_W'(scaled) + pred;
      if (sum > adpcm_pkg::SAMPLE_MAX) begin
         sample = adpcm_pkg::SAMPLE_W'(adpcm_pkg::SAMPLE_MAX);
      end else if (sum < adpcm_pkg::SAMPLE_MIN) begin
         sample = adpcm_pkg::SAMPLE_W'(adpcm_pkg::SAMPLE_MIN);
      end else begin
         sample = adpcm_pkg::SAMPLE_W'(sum);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign pos_eff  = req_port.channel_start ? adpcm_pkg::POS_HEADER : pos_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      header_in     = header_ff;
      byte_in       = byte_ff;
      nib_sel_in    = nib_sel_ff;
      hist1_in      = hist1_ff;
      hist2_in      = hist2_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_port.channel_start) begin
                  hist1_in = '0;
                  hist2_in = '0;
               end
               if (pos_eff == adpcm_pkg::POS_HEADER) begin
                  header_in = req_port.data_byte;
                  pos_in    = adpcm_pkg::POS_W'(1);
               end else begin
                  byte_in    = req_port.data_byte;
                  pos_in     = pos_eff + adpcm_pkg::POS_W'(1);
                  nib_sel_in = 1'b0;
                  state_in   = ST_PROD1;
               end
            end
         end
         ST_PROD1: begin
            state_in = ST_PROD2;
         end
         ST_PROD2: begin
            state_in = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            hist2_in = hist1_ff;
            hist1_in = sample;
            if (nib_sel_ff) begin
               second_in = sample;
               state_in  = ST_PUSH;
            end else begin
               first_in   = sample;
               nib_sel_in = 1'b1;
               state_in   = ST_PROD1;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = first_ff;
               rsp_second_in = second_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= adpcm_pkg::POS_HEADER;
         header_ff    <= '0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         header_ff    <= header_in;
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff       <= byte_in;
      nib_sel_ff    <= nib_sel_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.first_sample  = rsp_first_ff;
   assign rsp_port.second_sample = rsp_second_ff;

endmodule
`default_nettype wire

// File: hdl/adpcm_coef.sv
// Coefficient pair register file with one read port selected by the frame header.
`default_nettype none
module adpcm_coef (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [adpcm_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  wire logic [adpcm_pkg::CSR_DATA_W-1:0]    wr_data,
   input  wire logic [adpcm_pkg::SEL_W-1:0]         rd_sel,
   output logic signed [adpcm_pkg::COEF_W-1:0]      coef1,
   output logic signed [adpcm_pkg::COEF_W-1:0]      coef2
);

   logic [adpcm_pkg::CSR_DATA_W-1:0] pair_ff [adpcm_pkg::COEF_PAIRS];
   logic                             hit;

   assign hit = wr_en &&
                (wr_index < adpcm_pkg::CSR_INDEX_W'(adpcm_pkg::COEF_PAIRS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < adpcm_pkg::COEF_PAIRS; i++) begin
            pair_ff[i] <= '0;
         end
      end else if (hit) begin
         pair_ff[wr_index[adpcm_pkg::SEL_W-1:0]] <= wr_data;
      end
   end

   assign coef1 = pair_ff[rd_sel][adpcm_pkg::CSR_DATA_W-1:adpcm_pkg::COEF_W];
   assign coef2 = pair_ff[rd_sel][adpcm_pkg::COEF_W-1:0];

endmodule
`default_nettype wire

// File: hdl/adpcm_mac.sv
// Shared signed multiply-accumulate unit for the predictor sum.
`default_nettype none
module adpcm_mac (
   input  wire logic                                 clock,
   input  wire adpcm_pkg::mac_ctl_type               ctl,
   input  wire logic signed [adpcm_pkg::COEF_W-1:0]  op_a,
   input  wire logic signed [adpcm_pkg::SAMPLE_W-1:0] op_b,
   output logic signed [adpcm_pkg::ACC_W-1:0]        acc
);

   logic signed [adpcm_pkg::PROD_W-1:0] prod;
   logic signed [adpcm_pkg::ACC_W-1:0]  base;
   logic signed [adpcm_pkg::ACC_W-1:0]  acc_in;
   logic signed [adpcm_pkg::ACC_W-1:0]  acc_ff;

   always_comb begin
      prod   = op_a * op_b;
      base   = ctl.load ? adpcm_pkg::ROUND_BIAS : acc_ff;
      acc_in = base + adpcm_pkg::ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// File: hdl/adpcm_checker.sv
// Port-level checks for the DSP ADPCM decoder, bound to the top level.
`default_nettype none
module adpcm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 req_channel_start,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [adpcm_pkg::SAMPLE_W-1:0] rsp_first_sample,
   input wire logic signed [adpcm_pkg::SAMPLE_W-1:0] rsp_second_sample
);

   localparam logic signed [adpcm_pkg::SAMPLE_W-1:0] NEG_FULL =
      {1'b1, {(adpcm_pkg::SAMPLE_W-1){1'b0}}};

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_first_sample) && $stable(rsp_second_sample))
      else $error("output word changed or dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_sample != NEG_FULL) && (rsp_second_sample != NEG_FULL))
      else $error("sample outside clamp range");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_channel_start |=> req_ready)
      else $error("header word did not leave input ready");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind dsp_adpcm_decoder adpcm_checker u_adpcm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .req_channel_start (req_port.channel_start),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_first_sample  (rsp_port.first_sample),
   .rsp_second_sample (rsp_port.second_sample)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the DSP ADPCM decoder: directed table, random frames, stalls.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REG_COEF_PAIR_0 = 0;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_BYTES     = 82;
   localparam int SETTLE_CYCLES   = 20;

   typedef struct packed {
      logic signed [adpcm_pkg::SAMPLE_W-1:0] first_sample;
      logic signed [adpcm_pkg::SAMPLE_W-1:0] second_sample;
   } pcm_pair_type;

   typedef struct packed {
      logic                         start;
      logic [adpcm_pkg::BYTE_W-1:0] data_byte;
      logic                         typed;
      pcm_pair_type                 pair;
   } stim_row_type;

   localparam int RESET_ROWS = 13;
   localparam int COEF_ROWS  = 12;

   // coefficients at reset are zero, so every sample is the scaled nibble, clamped
   localparam stim_row_type reset_rows [RESET_ROWS] = '{
      '{1'b1, 8'h00, 1'b0, '{16'sd0, 16'sd0}},
      '{1'b0, 8'h7F, 1'b1, '{16'sd7, -16'sd1}},
      '{1'b0, 8'h80, 1'b1, '{-16'sd8, 16'sd0}},
      '{1'b1, 8'h8F, 1'b0, '{16'sd0, 16'sd0}},
      '{1'b0, 8'h78, 1'b1, '{16'sd32767, -16'sd32767}},
      '{1'b0, 8'h87, 1'b1, '{-16'sd32767, 16'sd32767}},
      '{1'b0, 8'h00, 1'b1, '{16'sd0, 16'sd0}},
      '{1'b0, 8'hFF, 1'b1, '{-16'sd32767, -16'sd32767}},
      '{1'b0, 8'h11, 1'b1, '{16'sd32767, 16'sd32767}},
      '{1'b0, 8'h01, 1'b1, '{16'sd0, 16'sd32767}},
      '{1'b0, 8'h10, 1'b1, '{16'sd32767, 16'sd0}},
      '{1'b0, 8'hFE, 1'b0, '{16'sd0, 16'sd0}},
      '{1'b0, 8'hE1, 1'b1, '{-16'sd32767, 16'sd16384}}
   };

   localparam logic [adpcm_pkg::CSR_DATA_W-1:0] extreme_coefs [adpcm_pkg::COEF_PAIRS] = '{
      32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
      32'h0800_0000, 32'h0F00_F900, 32'hFFFF_0001, 32'h0000_0000
   };

   localparam stim_row_type coef_rows [COEF_ROWS] = '{
      '{1'b1, 8'h0F, 1'b0, '0},
      '{1'b0, 8'h77, 1'b0, '0},
      '{1'b0, 8'h88, 1'b0, '0},
      '{1'b1, 8'h1F, 1'b0, '0},
      '{1'b0, 8'h77, 1'b0, '0},
      '{1'b0, 8'h88, 1'b0, '0},
      '{1'b1, 8'h2C, 1'b0, '0},
      '{1'b0, 8'h7F, 1'b0, '0},
      '{1'b1, 8'h3C, 1'b0, '0},
      '{1'b0, 8'h80, 1'b0, '0},
      '{1'b1, 8'h40, 1'b0, '0},
      '{1'b0, 8'h12, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   adpcm_req_if req_bus ();
   adpcm_rsp_if rsp_bus ();
   adpcm_csr_if csr_bus ();

   dsp_adpcm_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   logic [adpcm_pkg::CSR_DATA_W-1:0]      coef_regs [adpcm_pkg::COEF_PAIRS];
   logic [adpcm_pkg::POS_W-1:0]           frame_pos;
   logic [adpcm_pkg::BYTE_W-1:0]          header_reg;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_new;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_old;

   pcm_pair_type pending_pairs [$];
   int unsigned  mismatch_count = 0;
   bit           idle_on = 1'b1;
   int unsigned  stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom);
         default: return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   function automatic logic signed [adpcm_pkg::SAMPLE_W-1:0] predict_sample(
      logic [adpcm_pkg::NIB_W-1:0] nib,
      logic signed [adpcm_pkg::COEF_W-1:0] c1,
      logic signed [adpcm_pkg::COEF_W-1:0] c2,
      logic [adpcm_pkg::SHIFT_W-1:0] shift);
      longint acc;
      longint s;
      acc = 64'sd1024 + longint'(c1) * longint'(hist_new) + longint'(c2) * longint'(hist_old);
      s = longint'($signed(nib)) * (longint'(1) << shift) + (acc >>> adpcm_pkg::PRED_SHIFT);
      if (s > 32767) s = 32767;
      else if (s < -32767) s = -32767;
      hist_old = hist_new;
      hist_new = s[adpcm_pkg::SAMPLE_W-1:0];
      return s[adpcm_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic bit decode_byte(logic start, logic [adpcm_pkg::BYTE_W-1:0] b,
                                      output pcm_pair_type pair);
      logic [adpcm_pkg::SEL_W-1:0]         sel;
      logic signed [adpcm_pkg::COEF_W-1:0] c1;
      logic signed [adpcm_pkg::COEF_W-1:0] c2;
      pair = '0;
      if (start) begin
         hist_new  = '0;
         hist_old  = '0;
         frame_pos = adpcm_pkg::POS_HEADER;
      end
      if (frame_pos == adpcm_pkg::POS_HEADER) begin
         header_reg = b;
         frame_pos  = adpcm_pkg::POS_W'(1);
         return 1'b0;
      end
      sel = header_reg[6:4];
      c1  = coef_regs[sel][31:16];
      c2  = coef_regs[sel][15:0];
      pair.first_sample  = predict_sample(b[7:4], c1, c2,
                                          header_reg[adpcm_pkg::SHIFT_W-1:0]);
      pair.second_sample = predict_sample(b[3:0], c1, c2,
                                          header_reg[adpcm_pkg::SHIFT_W-1:0]);
      frame_pos = frame_pos + adpcm_pkg::POS_W'(1);
      return 1'b1;
   endfunction

   task automatic send_byte(input logic start, input logic [adpcm_pkg::BYTE_W-1:0] b,
                            input logic typed, input pcm_pair_type typed_pair);
      int unsigned  gap;
      pcm_pair_type pair;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.channel_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      if (decode_byte(start, b, pair)) pending_pairs.push_back(typed ? typed_pair : pair);
   endtask

   task automatic write_csr(input logic [adpcm_pkg::CSR_INDEX_W-1:0] index,
                            input logic [adpcm_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (index < adpcm_pkg::COEF_PAIRS) coef_regs[index] = data;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stall the sample output at random
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      pcm_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected sample pair: first_sample %0d, second_sample %0d",
                   rsp_bus.first_sample, rsp_bus.second_sample);
            mismatch_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_bus.first_sample !== want.first_sample) begin
               $error("first_sample: expected %0d, got %0d",
                      want.first_sample, rsp_bus.first_sample);
               mismatch_count++;
            end
            if (rsp_bus.second_sample !== want.second_sample) begin
               $error("second_sample: expected %0d, got %0d",
                      want.second_sample, rsp_bus.second_sample);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned                   kind;
      int unsigned                   run;
      int unsigned                   sent;
      logic [adpcm_pkg::BYTE_W-1:0]  hdr;
      logic [adpcm_pkg::SHIFT_W-1:0] shift;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = '0;
      req_bus.channel_start = 1'b0;
      rsp_bus.ready         = 1'b1;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      for (int i = 0; i < adpcm_pkg::COEF_PAIRS; i++) coef_regs[i] = '0;
      frame_pos  = adpcm_pkg::POS_HEADER;
      header_reg = '0;
      hist_new   = '0;
      hist_old   = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (reset_rows[i])
         send_byte(reset_rows[i].start, reset_rows[i].data_byte,
                   reset_rows[i].typed, reset_rows[i].pair);
      drain();

      for (int i = 0; i < adpcm_pkg::COEF_PAIRS; i++)
         write_csr(adpcm_pkg::CSR_INDEX_W'(REG_COEF_PAIR_0 + i), extreme_coefs[i]);
      csr_bus.valid <= 1'b0;
      foreach (coef_rows[i])
         send_byte(coef_rows[i].start, coef_rows[i].data_byte, 1'b0, '0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 2);
         for (int i = 0; i < adpcm_pkg::COEF_PAIRS; i++)
            write_csr(adpcm_pkg::CSR_INDEX_W'(REG_COEF_PAIR_0 + i),
                      {pick_coef(), pick_coef()});
         write_csr(adpcm_pkg::CSR_INDEX_W'($urandom_range(2**adpcm_pkg::CSR_INDEX_W - 1,
                                                          adpcm_pkg::COEF_PAIRS)),
                   $urandom);
         csr_bus.valid <= 1'b0;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
               shift = ($urandom_range(0, 3) == 0)
                          ? adpcm_pkg::SHIFT_W'($urandom_range(0, 15))
                          : adpcm_pkg::SHIFT_W'($urandom_range(0, 11));
               hdr = {1'($urandom), 3'($urandom), shift};
               send_byte(($urandom_range(0, 2) == 0) ||
                         (frame_pos != adpcm_pkg::POS_HEADER),
                         hdr, 1'b0, '0);
               run = (kind == 7) ? $urandom_range(1, 6) : 7;
               repeat (run) send_byte(1'b0, adpcm_pkg::BYTE_W'($urandom), 1'b0, '0);
               sent += run + 1;
            end else begin
               run = $urandom_range(1, 8);
               repeat (run)
                  send_byte($urandom_range(0, 5) == 0, adpcm_pkg::BYTE_W'($urandom),
                            1'b0, '0);
               sent += run;
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
